/* rtl/per_point_min_max_hold_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the min/max hold block.
// ----------------------------------------------------------------------------
`ifndef PER_POINT_MIN_MAX_HOLD_MACROS_SVH
`define PER_POINT_MIN_MAX_HOLD_MACROS_SVH

// same-cycle implication
`define PPMM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPMM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// invariant
`define PPMM_ASSERT_ALW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

/* rtl/ppmm_pkg.sv */
// ----------------------------------------------------------------------------
// ppmm_pkg
// Types and constants of the per-point min/max hold block.
// ----------------------------------------------------------------------------
package ppmm_pkg;

  localparam int POINTS     = 512;
  localparam int ADDR_W     = $clog2(POINTS);
  localparam int PIX_W      = 10;
  localparam int CNT_W      = 10;
  localparam int MIN_POINTS = 2;

  localparam logic [CNT_W:0]   PTS_LIM        = (CNT_W + 1)'(POINTS);
  localparam logic [ADDR_W-1:0] PTR_LAST      = ADDR_W'(POINTS - 1);
  localparam logic [PIX_W-1:0] RST_PIXEL_LOW  = PIX_W'(0);
  localparam logic [PIX_W-1:0] RST_PIXEL_HIGH = PIX_W'(239);

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_CLEAR  = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    CFG_ENABLE        = 3'd0,
    CFG_TRACE_SELECT  = 3'd1,
    CFG_POINTS_IN_USE = 3'd2,
    CFG_PIXEL_LOW     = 3'd3,
    CFG_PIXEL_HIGH    = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_MERGE,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              func;
    logic [2:0]        trace_id;
    logic [9:0]        point_index;
    logic signed [15:0] sample_pixel;
  } in_t;

  typedef struct packed {
    logic             accepted;
    logic [PIX_W-1:0] point_min;
    logic [PIX_W-1:0] point_max;
    logic [CNT_W-1:0] valid_points;
    logic             sweep_complete;
  } out_t;

  typedef struct packed {
    logic             enable;
    logic [2:0]       trace_select;
    logic [CNT_W-1:0] points_in_use;
    logic [PIX_W-1:0] pixel_low;
    logic [PIX_W-1:0] pixel_high;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] min_val;
    logic [PIX_W-1:0] max_val;
    logic             vld;
  } ent_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic init_wr;
    logic clr_wr;
    logic clr_done;
  } ctl_cmd_t;

  typedef struct packed {
    logic ptr_last;
    logic out_free;
  } ctl_sts_t;

endpackage

/* rtl/per_point_min_max_hold.sv */
// ----------------------------------------------------------------------------
// per_point_min_max_hold
// Min/max hold envelope over the sweep points of one selected trace.
//
// Each input item yields one result. For a sample, the intake cycle reads
// the point from the single-port store and the merge state then merges,
// writes back and loads the result register once the output is free.
// A clear item sweeps the store one entry per cycle, then loads its result.
// After reset the block runs a clearing pass over all POINTS (512) entries
// with in_stall high; configuration writes are taken during that pass. The
// result register lets a new item enter while the previous result waits.
// ----------------------------------------------------------------------------
`include "per_point_min_max_hold_macros.svh"

module per_point_min_max_hold import ppmm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:        cfg_nxt.enable        = cfg_data[0];
        CFG_TRACE_SELECT:  cfg_nxt.trace_select  = cfg_data[2:0];
        CFG_POINTS_IN_USE: cfg_nxt.points_in_use = cfg_data[CNT_W-1:0];
        CFG_PIXEL_LOW:     cfg_nxt.pixel_low     = cfg_data[PIX_W-1:0];
        CFG_PIXEL_HIGH:    cfg_nxt.pixel_high    = cfg_data[PIX_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{enable: 1'b0, trace_select: 3'd0, points_in_use: '0,
                 pixel_low: RST_PIXEL_LOW, pixel_high: RST_PIXEL_HIGH};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ppmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppmm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `PPMM_ASSERT_NXT(a_busy_after_transfer, in_valid && !in_stall, in_stall, "intake not busy")
  `PPMM_ASSERT_NXT(a_load_sets_valid, cmd.commit || cmd.clr_done, out_valid, "result lost")
  `PPMM_ASSERT_IMP(a_valid_from_load, $rose(out_valid),
                   $past(cmd.commit) || $past(cmd.clr_done), "result invented")
  `PPMM_ASSERT_ALW(a_cmd_onehot, $onehot0(cmd), "conflicting commands")

endmodule

/* rtl/ppmm_ctrl.sv */
// ----------------------------------------------------------------------------
// ppmm_ctrl
// Sequencer: reset sweep, item intake, merge, clear sweep and result load.
// ----------------------------------------------------------------------------
module ppmm_ctrl import ppmm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_func,
  output logic     in_stall,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:  if (sts.ptr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_func == FUNC_CLEAR) ? S_CLEAR : S_MERGE;
        end
      end
      S_MERGE: if (sts.out_free) state_nxt = S_IDLE;
      S_CLEAR: if (sts.ptr_last) state_nxt = S_DONE;
      S_DONE:  if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_INIT:  cmd.init_wr = 1'b1;
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_MERGE: cmd.commit   = sts.out_free;
      S_CLEAR: cmd.clr_wr   = 1'b1;
      S_DONE:  cmd.clr_done = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/ppmm_dp.sv */
// ----------------------------------------------------------------------------
// ppmm_dp
// Datapath: point store, clamp and merge, counters and result register.
// ----------------------------------------------------------------------------
module ppmm_dp import ppmm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  in_t      in_data,
  input  ctl_cmd_t cmd,
  output ctl_sts_t sts,
  output logic     out_valid,
  input  logic     out_stall,
  output out_t     out_data
);

  ent_t              mem [POINTS];
  ent_t              rdata_r;
  in_t               item_r;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic              complete_r, complete_nxt;
  logic              out_valid_r;
  out_t              out_data_r, out_data_nxt;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  ent_t              wdata;
  logic              in_rng;
  logic              hit;
  logic signed [15:0] lo_s, hi_s, pix_a, pix_b;
  logic [PIX_W-1:0]  pix;
  ent_t              merged;

  assign sts.ptr_last = (ptr_r == PTR_LAST);
  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  assign in_rng = ({1'b0, item_r.point_index} < PTS_LIM);
  assign hit    = cfg.enable && (item_r.trace_id == cfg.trace_select)
                  && (cfg.points_in_use >= CNT_W'(MIN_POINTS)) && in_rng;

  assign lo_s  = $signed({6'b0, cfg.pixel_low});
  assign hi_s  = $signed({6'b0, cfg.pixel_high});
  assign pix_a = (item_r.sample_pixel < lo_s) ? lo_s : item_r.sample_pixel;
  assign pix_b = (pix_a > hi_s) ? hi_s : pix_a;
  assign pix   = pix_b[PIX_W-1:0];

  always_comb begin
    merged.vld     = 1'b1;
    merged.min_val = (pix < rdata_r.min_val) ? pix : rdata_r.min_val;
    merged.max_val = (pix > rdata_r.max_val) ? pix : rdata_r.max_val;
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr_r;
    wdata = '0;
    if (cmd.init_wr) begin
      we    = 1'b1;
      wdata = '{min_val: RST_PIXEL_HIGH, max_val: RST_PIXEL_LOW, vld: 1'b0};
    end else if (cmd.clr_wr) begin
      we    = 1'b1;
      wdata = '{min_val: cfg.pixel_high, max_val: cfg.pixel_low, vld: 1'b0};
    end else if (cmd.commit && hit) begin
      we    = 1'b1;
      waddr = item_r.point_index[ADDR_W-1:0];
      wdata = merged;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.capture) begin
      rdata_r <= mem[in_data.point_index[ADDR_W-1:0]];
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.init_wr || cmd.clr_wr) begin
      ptr_nxt = sts.ptr_last ? '0 : ptr_r + 1'b1;
    end
  end

  always_comb begin
    total_nxt    = total_r;
    complete_nxt = complete_r;
    if (cmd.clr_done) begin
      total_nxt    = '0;
      complete_nxt = 1'b0;
    end else if (cmd.commit && hit) begin
      total_nxt = total_r + CNT_W'(!rdata_r.vld);
      if (item_r.point_index == cfg.points_in_use - 1'b1) begin
        complete_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_data_nxt.accepted       = 1'b0;
    out_data_nxt.point_min      = '0;
    out_data_nxt.point_max      = '0;
    out_data_nxt.valid_points   = total_nxt;
    out_data_nxt.sweep_complete = complete_nxt;
    if (cmd.commit) begin
      if (hit) begin
        out_data_nxt.accepted  = 1'b1;
        out_data_nxt.point_min = merged.min_val;
        out_data_nxt.point_max = merged.max_val;
      end else if (in_rng) begin
        out_data_nxt.point_min = rdata_r.min_val;
        out_data_nxt.point_max = rdata_r.max_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.commit || cmd.clr_done) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      total_r     <= '0;
      complete_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r      <= ptr_nxt;
      total_r    <= total_nxt;
      complete_r <= complete_nxt;
      if (cmd.commit || cmd.clr_done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-point min/max hold envelope. A local
// predictor mirrors the register settings and the per-point min/max/valid
// store and computes the result of every input transfer; results are checked
// in order, field by field. Directed items cover reset contents, clamping,
// ignored samples, sweep completion, clears and odd bound/point settings;
// random sweeps with noise follow under several sender/receiver idle modes.
// ----------------------------------------------------------------------------
module tb;
  import ppmm_pkg::*;

  localparam int WATCHDOG_LIMIT    = 6000;
  localparam int ITEMS_PER_SETTING = 200;
  localparam int MAX_PRINTED       = 40;
  localparam int IN_W              = $bits(in_t);

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_t        in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [9:0] cfg_data  = '0;

  cfg_t             regs;
  logic [PIX_W-1:0] env_min [POINTS];
  logic [PIX_W-1:0] env_max [POINTS];
  bit               env_seen [POINTS];
  int               seen_total;
  bit               sweep_done;
  out_t             expected_q [$];

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int sweep_pos    = 0;
  int quiet_cycles = 0;
  int n_errors     = 0;
  int n_items      = 0;
  int n_results    = 0;
  int n_merged     = 0;
  int n_clears     = 0;
  int n_last_point = 0;
  int n_settings   = 0;

  per_point_min_max_hold dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MAX_PRINTED) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                n_results, name, got, want));
    end
  endtask

  function automatic void clear_envelope();
    for (int i = 0; i < POINTS; i++) begin
      env_min[i]  = regs.pixel_high;
      env_max[i]  = regs.pixel_low;
      env_seen[i] = 1'b0;
    end
    seen_total = 0;
    sweep_done = 1'b0;
  endfunction

  function automatic out_t envelope_step(input in_t it);
    out_t r;
    int   idx;
    int   pix;
    r   = '0;
    idx = int'(it.point_index);
    pix = int'($signed(it.sample_pixel));
    if (it.func == FUNC_CLEAR) begin
      clear_envelope();
      n_clears++;
    end else begin
      if (regs.enable && it.trace_id == regs.trace_select &&
          regs.points_in_use >= MIN_POINTS && idx < POINTS) begin
        if (pix < int'(regs.pixel_low)) pix = int'(regs.pixel_low);
        if (pix > int'(regs.pixel_high)) pix = int'(regs.pixel_high);
        if (!env_seen[idx]) begin
          env_seen[idx] = 1'b1;
          seen_total++;
        end
        if (pix < int'(env_min[idx])) env_min[idx] = PIX_W'(pix);
        if (pix > int'(env_max[idx])) env_max[idx] = PIX_W'(pix);
        if (idx == int'(regs.points_in_use) - 1) begin
          sweep_done = 1'b1;
          n_last_point++;
        end
        r.accepted = 1'b1;
        n_merged++;
      end
      if (idx < POINTS) begin
        r.point_min = env_min[idx];
        r.point_max = env_max[idx];
      end
    end
    r.valid_points   = CNT_W'(seen_total);
    r.sweep_complete = sweep_done;
    return r;
  endfunction

  function automatic in_t sample_item(input int trace, input int idx, input int pix);
    return '{func: FUNC_SAMPLE, trace_id: 3'(trace), point_index: 10'(idx),
             sample_pixel: 16'(pix)};
  endfunction

  function automatic in_t clear_item();
    return '{func: FUNC_CLEAR, trace_id: 3'($urandom), point_index: 10'($urandom),
             sample_pixel: 16'($urandom)};
  endfunction

  task automatic send_item(input in_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(envelope_step(it));
    n_items++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [9:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ENABLE:        regs.enable        = value[0];
      CFG_TRACE_SELECT:  regs.trace_select  = value[2:0];
      CFG_POINTS_IN_USE: regs.points_in_use = value;
      CFG_PIXEL_LOW:     regs.pixel_low     = value;
      CFG_PIXEL_HIGH:    regs.pixel_high    = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int en, input int trace, input int pts,
                                input int lo, input int hi);
    wait_idle();
    write_reg(CFG_ENABLE, 10'(en));
    write_reg(CFG_TRACE_SELECT, 10'(trace));
    write_reg(CFG_POINTS_IN_USE, 10'(pts));
    write_reg(CFG_PIXEL_LOW, 10'(lo));
    write_reg(CFG_PIXEL_HIGH, 10'(hi));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic pick_settings(input int k);
    int lo;
    int hi;
    int tmp;
    int pts;
    lo = $urandom_range(1023);
    hi = $urandom_range(1023);
    if (lo > hi && $urandom_range(3) != 0) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    case ($urandom_range(3))
      0:       pts = $urandom_range(20, MIN_POINTS);
      1:       pts = POINTS;
      2:       pts = $urandom_range(1023);
      default: pts = $urandom_range(POINTS, MIN_POINTS);
    endcase
    case (k)
      0:       apply_settings(1, $urandom_range(7), POINTS, 0, 1023);
      1:       apply_settings(1, $urandom_range(7), MIN_POINTS, 1023, 0);
      2:       apply_settings(1, $urandom_range(7), 1023, lo, hi);
      default: apply_settings($urandom_range(9) != 0, $urandom_range(7), pts, lo, hi);
    endcase
  endtask

  function automatic in_t next_random_item();
    in_t it;
    int  r;
    int  span;
    int  pix;
    r    = $urandom_range(99);
    span = (regs.points_in_use > POINTS) ? POINTS : int'(regs.points_in_use);
    if (r < 2) return clear_item();
    if (r < 82) begin
      if (span == 0) sweep_pos = $urandom_range(POINTS - 1);
      else sweep_pos = (sweep_pos + 1) % span;
      case ($urandom_range(3))
        0:       pix = int'($signed(16'($urandom)));
        1:       pix = $urandom_range(regs.pixel_high, regs.pixel_low);
        2:       pix = int'(regs.pixel_low) + int'($urandom_range(8)) - 4;
        default: pix = int'(regs.pixel_high) + int'($urandom_range(8)) - 4;
      endcase
      return sample_item(regs.trace_select, sweep_pos, pix);
    end
    it      = in_t'(IN_W'($urandom));
    it.func = FUNC_SAMPLE;
    return it;
  endfunction

  task automatic test_reset_state();
    send_item(sample_item(0, 0, 100));
    send_item(sample_item(0, POINTS - 1, -5));
    send_item(sample_item(0, POINTS, 0));
    send_item(sample_item(7, 1023, 32767));
  endtask

  task automatic test_clamp_and_merge();
    apply_settings(1, 5, 8, 10, 200);
    send_item(sample_item(5, 0, -32768));
    send_item(sample_item(5, 0, 32767));
    send_item(sample_item(5, 3, 120));
    send_item(sample_item(5, 1, 200));
    send_item(sample_item(5, 2, 9));
    send_item(clear_item());
  endtask

  task automatic test_ignored_samples();
    send_item(sample_item(4, 3, 50));
    send_item(sample_item(5, POINTS, 50));
    send_item(sample_item(5, 1023, 50));
    send_item(sample_item(5, POINTS - 1, 77));
    apply_settings(0, 5, 8, 10, 200);
    send_item(sample_item(5, 3, 50));
  endtask

  task automatic test_sweep_complete();
    apply_settings(1, 2, MIN_POINTS, 0, 1023);
    send_item(sample_item(2, 0, 0));
    send_item(sample_item(2, 1, 1023));
    send_item(clear_item());
    send_item(sample_item(2, 0, 512));
  endtask

  task automatic test_bound_corners();
    apply_settings(1, 2, 1, 0, 1023);
    send_item(sample_item(2, 0, 40));
    apply_settings(1, 2, 0, 0, 1023);
    send_item(sample_item(2, 0, 40));
    apply_settings(1, 2, 1023, 1023, 0);
    send_item(sample_item(2, POINTS - 1, -32768));
    apply_settings(1, 2, POINTS, 300, 100);
    send_item(sample_item(2, POINTS - 1, 500));
    send_item(sample_item(2, 0, 200));
  endtask

  task automatic test_random_traffic();
    int tx_modes [4] = '{0, 77, 0, 17};
    int rx_modes [4] = '{0, 0, 77, 17};
    int setting_no;
    setting_no = 0;
    for (int m = 0; m < 4; m++) begin
      for (int s = 0; s < 2; s++) begin
        pick_settings(setting_no);
        setting_no++;
        tx_idle_pct  = tx_modes[m];
        rx_stall_pct = rx_modes[m];
        for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
          send_item(next_random_item());
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", n_results));
      end else begin
        want = expected_q.pop_front();
        check_field("accepted", 16'(out_data.accepted), 16'(want.accepted));
        check_field("point_min", 16'(out_data.point_min), 16'(want.point_min));
        check_field("point_max", 16'(out_data.point_max), 16'(want.point_max));
        check_field("valid_points", 16'(out_data.valid_points),
                    16'(want.valid_points));
        check_field("sweep_complete", 16'(out_data.sweep_complete),
                    16'(want.sweep_complete));
      end
    end
    out_stall <= ($urandom_range(99) < rx_stall_pct);
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    regs = '{enable: 1'b0, trace_select: 3'd0, points_in_use: '0,
             pixel_low: RST_PIXEL_LOW, pixel_high: RST_PIXEL_HIGH};
    clear_envelope();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    test_reset_state();
    test_clamp_and_merge();
    test_ignored_samples();
    test_sweep_complete();
    test_bound_corners();
    test_random_traffic();
    wait_idle();
    repeat (20) @(posedge clk);
    if (expected_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
    end
    $display("Covered %0d items (%0d merged samples, %0d clears, %0d last-point hits)",
             n_items, n_merged, n_clears, n_last_point);
    $display("over %0d register settings and four idle modes; %0d results, %0d mismatches",
             n_settings, n_results, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ppmm_pkg.sv
rtl/ppmm_ctrl.sv
rtl/ppmm_dp.sv
rtl/per_point_min_max_hold.sv
tb/tb.sv
